>>> hdl/tkel_pkg.sv
// shared types and constants for the knife-edge loss block
`default_nettype none
package tkel_pkg;

  // input kind codes
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  // arithmetic widths, sized for the whole parameter range
  localparam int DIV_N = 72;
  localparam int DIV_D = 32;
  localparam int SQ_W  = 54;
  localparam int RT_W  = 27;
  localparam int C_W   = 16;
  localparam int H_W   = 42;

  // queue depth between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // fixed-point constants
  localparam logic [18:0] STEP_Q16   = 19'd491520;
  localparam logic [20:0] K173_Q16   = 21'd1133773;
  localparam logic [19:0] TEN_DB_Q16 = 20'd655360;
  localparam logic [18:0] TERM_MAX   = 19'd262144;
  localparam logic [23:0] SAT24      = 24'hFFFFFF;
  localparam logic [12:0] SAT13      = 13'h1FFF;
  localparam logic [31:0] SAT32      = 32'hFFFFFFFF;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_END    = 2'd1,
    OP_SAMPLE = 2'd2
  } tkel_op_t;

  // one queued job
  typedef struct packed {
    tkel_op_t          op;
    logic [23:0]       x;
    logic [23:0]       y;
    logic [23:0]       z;
    logic [13:0]       freq;
    logic [C_W-1:0]    c;
    logic              peak;
    logic              last;
    logic              short_p;
  } tkel_ent_t;

  typedef struct packed {
    logic div_go;
    logic sqrt_go;
  } tkel_req_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } tkel_rsp_t;

endpackage
`default_nettype wire

>>> hdl/tkel_front.sv
// front end: takes beats, tracks the sample window and finds peaks
`default_nettype none
module tkel_front
  import tkel_pkg::*;
#(
  parameter int MAX_SAMPLES = 8192
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [23:0] pos_x,
  input  wire logic [23:0] pos_y,
  input  wire logic [23:0] height,
  input  wire logic [13:0] freq_mhz,
  input  wire logic        path_last,
  output logic             push,
  output tkel_ent_t        push_ent,
  input  wire logic        full
);

  localparam int IDX_W = $clog2(MAX_SAMPLES + 1);

  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_next;
  logic [IDX_W-1:0]  idx_m1;
  logic signed [23:0] older;
  logic signed [23:0] newer;
  logic              accept;
  logic              room;
  logic              peak;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign room     = idx < IDX_W'(MAX_SAMPLES);
  assign idx_m1   = idx - IDX_W'(1);
  assign peak     = room && (idx >= IDX_W'(2)) && (newer > older) &&
                    (newer > $signed(height));
  assign idx_next = room ? idx + IDX_W'(1) : idx;

  // build the queue entry
  always_comb begin
    push_ent.op      = OP_SAMPLE;
    push_ent.x       = pos_x;
    push_ent.y       = pos_y;
    push_ent.z       = height;
    push_ent.freq    = freq_mhz;
    push_ent.c       = C_W'(idx_m1);
    push_ent.peak    = 1'b0;
    push_ent.last    = 1'b0;
    push_ent.short_p = 1'b0;
    push             = 1'b0;
    unique case (kind)
      KIND_START: begin
        push_ent.op = OP_START;
        push        = accept;
      end
      KIND_END: begin
        push_ent.op = OP_END;
        push        = accept;
      end
      KIND_SAMPLE: begin
        push_ent.z       = newer;
        push_ent.peak    = peak;
        push_ent.last    = path_last;
        push_ent.short_p = idx_next < IDX_W'(4);
        push             = accept && (peak || path_last);
      end
      default: push = 1'b0;
    endcase
  end

  // sample window state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      older <= '0;
      newer <= '0;
    end else if (accept) begin
      if (kind == KIND_START || kind == KIND_END) begin
        idx   <= '0;
        older <= '0;
        newer <= '0;
      end else if (kind == KIND_SAMPLE) begin
        if (path_last) begin
          idx   <= '0;
          older <= '0;
          newer <= '0;
        end else if (room) begin
          idx   <= idx_next;
          older <= newer;
          newer <= $signed(height);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/tkel_fifo.sv
// short job queue between front and back
`default_nettype none
module tkel_fifo
  import tkel_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  tkel_ent_t      push_ent,
  output logic           full,
  input  wire logic      pop,
  output logic           empty,
  output tkel_ent_t      head
);

  tkel_ent_t        slots [Q_DEPTH];
  logic [Q_AW-1:0]  wr;
  logic [Q_AW-1:0]  rd;
  logic [Q_AW:0]    cnt;

  assign full  = cnt == (Q_AW+1)'(Q_DEPTH);
  assign empty = cnt == '0;
  assign head  = slots[rd];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr] <= push_ent;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= '0;
      rd  <= '0;
      cnt <= '0;
    end else begin
      if (push) wr <= wr + Q_AW'(1);
      if (pop)  rd <= rd + Q_AW'(1);
      if (push && !pop)      cnt <= cnt + (Q_AW+1)'(1);
      else if (pop && !push) cnt <= cnt - (Q_AW+1)'(1);
    end
  end

endmodule
`default_nettype wire

>>> hdl/tkel_arith.sv
// shared iterative divider and square root, one bit per cycle
`default_nettype none
module tkel_arith
  import tkel_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  tkel_req_t             req,
  input  wire logic [DIV_N-1:0] div_num,
  input  wire logic [DIV_D-1:0] div_den,
  input  wire logic [SQ_W-1:0]  sq_in,
  output tkel_rsp_t             rsp,
  output logic [DIV_N-1:0]      quot,
  output logic [RT_W-1:0]       root
);

  // divider registers
  logic             dv_busy;
  logic             div_done;
  logic [6:0]       dv_cnt;
  logic [DIV_D-1:0] rem;
  logic [DIV_N-1:0] qr;
  logic [DIV_D-1:0] den;
  logic [DIV_D:0]   rem_s;
  logic [DIV_D:0]   rem_d;
  logic             ge;

  // square root registers
  logic             sq_busy;
  logic             sqrt_done;
  logic [4:0]       sq_cnt;
  logic [SQ_W-1:0]  v;
  logic [SQ_W-1:0]  r;
  logic [SQ_W-1:0]  b;
  logic [SQ_W:0]    rb;
  logic             take;

  assign rem_s = {rem, qr[DIV_N-1]};
  assign rem_d = rem_s - {1'b0, den};
  assign ge    = rem_s >= {1'b0, den};
  assign quot  = qr;

  assign rb    = {1'b0, r} + {1'b0, b};
  assign take  = {1'b0, v} >= rb;
  assign root  = r[RT_W-1:0];

  assign rsp.div_done  = div_done;
  assign rsp.sqrt_done = sqrt_done;

  // restoring divide
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy  <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (req.div_go) begin
        dv_busy <= 1'b1;
        dv_cnt  <= '0;
        rem     <= '0;
        qr      <= div_num;
        den     <= div_den;
      end else if (dv_busy) begin
        rem    <= ge ? rem_d[DIV_D-1:0] : rem_s[DIV_D-1:0];
        qr     <= {qr[DIV_N-2:0], ge};
        dv_cnt <= dv_cnt + 7'd1;
        if (dv_cnt == 7'(DIV_N - 1)) begin
          dv_busy  <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  // digit-pair square root
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy   <= 1'b0;
      sqrt_done <= 1'b0;
    end else begin
      sqrt_done <= 1'b0;
      if (req.sqrt_go) begin
        sq_busy <= 1'b1;
        sq_cnt  <= '0;
        v       <= sq_in;
        r       <= '0;
        b       <= SQ_W'(1) << (SQ_W - 2);
      end else if (sq_busy) begin
        if (take) begin
          v <= v - rb[SQ_W-1:0];
          r <= (r >> 1) + b;
        end else begin
          r <= r >> 1;
        end
        b      <= b >> 2;
        sq_cnt <= sq_cnt + 5'd1;
        if (sq_cnt == 5'(RT_W - 1)) begin
          sq_busy   <= 1'b0;
          sqrt_done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/tkel_back.sv
// back end: path geometry, per-peak loss and the result register
`default_nettype none
module tkel_back
  import tkel_pkg::*;
#(
  parameter int POS_FRAC_BITS = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             empty,
  input  tkel_ent_t             head,
  output logic                  pop,
  output tkel_req_t             req,
  output logic [DIV_N-1:0]      div_num,
  output logic [DIV_D-1:0]      div_den,
  output logic [SQ_W-1:0]       sq_in,
  input  tkel_rsp_t             rsp,
  input  wire logic [DIV_N-1:0] quot,
  input  wire logic [RT_W-1:0]  root,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [15:0]           out_loss,
  output logic [12:0]           out_peaks,
  output logic                  out_short
);

  localparam int D_SH = 8 - POS_FRAC_BITS;
  localparam int H_SH = 16 - POS_FRAC_BITS;

  typedef enum logic [22:0] {
    S_IDLE   = 23'd1 << 0,
    E_DIFF   = 23'd1 << 1,
    E_SQ     = 23'd1 << 2,
    E_ACC    = 23'd1 << 3,
    E_SQRTH  = 23'd1 << 4,
    E_SQRTL  = 23'd1 << 5,
    E_MULS   = 23'd1 << 6,
    E_DIVS   = 23'd1 << 7,
    E_HSQ    = 23'd1 << 8,
    E_HACC   = 23'd1 << 9,
    E_HSQRT  = 23'd1 << 10,
    P_D1M    = 23'd1 << 11,
    P_CHK    = 23'd1 << 12,
    P_PRM    = 23'd1 << 13,
    P_TDIV   = 23'd1 << 14,
    P_QDIV   = 23'd1 << 15,
    P_ROOT   = 23'd1 << 16,
    P_F1     = 23'd1 << 17,
    P_H      = 23'd1 << 18,
    P_TERM   = 23'd1 << 19,
    P_TW     = 23'd1 << 20,
    P_ACC    = 23'd1 << 21,
    S_FIN    = 23'd1 << 22
  } tkel_bst_t;

  tkel_bst_t state;
  tkel_ent_t ent;

  // path state
  logic [23:0]        start_pt [3];
  logic signed [19:0] stv [3];
  logic [23:0]        hl;
  logic [24:0]        len3;
  logic [13:0]        f;
  logic [19:0]        hstep;
  logic [31:0]        loss;
  logic [12:0]        peaks;

  // working registers
  logic [24:0]        mg [3];
  logic [2:0]         neg;
  logic [1:0]         ci;
  logic [63:0]        p;
  logic [49:0]        acc;
  logic [49:0]        sq2;
  logic [31:0]        d1;
  logic [31:0]        d2;
  logic [31:0]        f1;
  logic signed [H_W-1:0] ps;
  logic signed [H_W-1:0] h;

  // combinational helpers
  logic [24:0]        mg_sel;
  logic [19:0]        stm_sel;
  logic [49:0]        m_sq;
  logic [43:0]        m_st;
  logic [39:0]        m_hs;
  logic [35:0]        m_d1;
  logic [63:0]        m_pr;
  logic [47:0]        m_k;
  logic signed [36:0] m_z;
  logic [31:0]        dd;
  logic [27:0]        d1c;
  logic [47:0]        f1_sum;
  logic [31:0]        f1c;
  logic [H_W-1:0]     habs;
  logic [46:0]        habs20;
  logic signed [H_W-1:0] szx;
  logic signed [H_W-1:0] phx;
  logic               hpos;
  logic [DIV_N:0]     add_v;
  logic [DIV_N:0]     total;
  logic [24:0]        dlx [3];
  logic [24:0]        dln [3];

  assign pop     = (state == S_IDLE) && !empty && !out_valid;
  assign mg_sel  = mg[ci];
  assign stm_sel = stv[ci][19] ? 20'(-stv[ci]) : 20'(stv[ci]);
  assign m_sq    = mg_sel * mg_sel;
  assign m_st    = mg_sel * STEP_Q16;
  assign m_hs    = stm_sel * stm_sel;
  assign m_d1    = ent.c * hstep;
  assign m_pr    = d1 * d2;
  assign m_k     = p[RT_W-1:0] * K173_Q16;
  assign m_z     = stv[2] * $signed({1'b0, ent.c});
  assign dd      = {8'b0, hl} << D_SH;
  assign d1c     = p[35:8];
  assign f1_sum  = p[47:0] + 48'd32768;
  assign f1c     = f1_sum[47:16];
  assign habs    = h[H_W-1] ? H_W'(-h) : H_W'(h);
  assign habs20  = (47'(habs) << 4) + (47'(habs) << 2);
  assign szx     = $signed({{(H_W-24){start_pt[2][23]}}, start_pt[2]}) <<< H_SH;
  assign phx     = $signed({{(H_W-24){ent.z[23]}}, ent.z}) <<< H_SH;
  assign hpos    = !h[H_W-1] && (h != '0);
  // loss of this peak in Q8.8, formed from the divider result
  assign add_v   = hpos ? (((DIV_N+1)'(TEN_DB_Q16) - (DIV_N+1)'(quot)) >> 8)
                        : (((DIV_N+1)'(TEN_DB_Q16) + (DIV_N+1)'(quot)) >> 8);
  assign total   = (DIV_N+1)'(loss) + add_v;

  // end minus start per axis
  always_comb begin
    dlx[0] = {ent.x[23], ent.x} - {start_pt[0][23], start_pt[0]};
    dlx[1] = {ent.y[23], ent.y} - {start_pt[1][23], start_pt[1]};
    dlx[2] = {ent.z[23], ent.z} - {start_pt[2][23], start_pt[2]};
    for (int i = 0; i < 3; i++) begin
      dln[i] = dlx[i][24] ? 25'(-dlx[i]) : dlx[i];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      req         <= '0;
      out_valid   <= 1'b0;
      loss        <= '0;
      peaks       <= '0;
      hl          <= '0;
      f           <= '0;
      hstep       <= '0;
      for (int i = 0; i < 3; i++) begin
        start_pt[i] <= '0;
        stv[i]      <= '0;
      end
    end else begin
      req <= '0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            ent <= head;
            unique case (head.op)
              OP_START: begin
                start_pt[0] <= head.x;
                start_pt[1] <= head.y;
                start_pt[2] <= head.z;
                loss        <= '0;
                peaks       <= '0;
              end
              OP_END:    state <= E_DIFF;
              OP_SAMPLE: state <= head.peak ? P_D1M : S_FIN;
              default:   state <= S_IDLE;
            endcase
          end
        end
        // geometry of a new path
        E_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            mg[i]  <= dln[i];
            neg[i] <= dlx[i][24];
          end
          f     <= (ent.freq == '0) ? 14'd1 : ent.freq;
          loss  <= '0;
          peaks <= '0;
          acc   <= '0;
          ci    <= '0;
          state <= E_SQ;
        end
        E_SQ: begin
          p     <= 64'(m_sq);
          state <= E_ACC;
        end
        E_ACC: begin
          acc <= acc + p[49:0];
          if (ci == 2'd1) sq2 <= acc + p[49:0];
          if (ci == 2'd2) begin
            sq_in       <= SQ_W'(sq2);
            req.sqrt_go <= 1'b1;
            state       <= E_SQRTH;
          end else begin
            ci    <= ci + 2'd1;
            state <= E_SQ;
          end
        end
        E_SQRTH: begin
          if (rsp.sqrt_done) begin
            hl          <= (root > RT_W'(SAT24)) ? SAT24 : root[23:0];
            sq_in       <= SQ_W'(acc);
            req.sqrt_go <= 1'b1;
            state       <= E_SQRTL;
          end
        end
        E_SQRTL: begin
          if (rsp.sqrt_done) begin
            len3 <= root[24:0];
            ci   <= '0;
            acc  <= '0;
            if (root == '0) begin
              for (int i = 0; i < 3; i++) stv[i] <= '0;
              state <= E_HSQ;
            end else begin
              state <= E_MULS;
            end
          end
        end
        E_MULS: begin
          div_num    <= DIV_N'(m_st + 44'(len3 >> 1));
          div_den    <= DIV_D'(len3);
          req.div_go <= 1'b1;
          state      <= E_DIVS;
        end
        E_DIVS: begin
          if (rsp.div_done) begin
            stv[ci] <= neg[ci] ? -$signed(quot[19:0]) : $signed(quot[19:0]);
            if (ci == 2'd2) begin
              ci    <= '0;
              acc   <= '0;
              state <= E_HSQ;
            end else begin
              ci    <= ci + 2'd1;
              state <= E_MULS;
            end
          end
        end
        E_HSQ: begin
          p     <= 64'(m_hs);
          state <= E_HACC;
        end
        E_HACC: begin
          acc <= acc + 50'(p[39:0]);
          if (ci == 2'd1) begin
            sq_in       <= SQ_W'(acc + 50'(p[39:0]));
            req.sqrt_go <= 1'b1;
            state       <= E_HSQRT;
          end else begin
            ci    <= ci + 2'd1;
            state <= E_HSQ;
          end
        end
        E_HSQRT: begin
          if (rsp.sqrt_done) begin
            hstep <= root[19:0];
            state <= S_IDLE;
          end
        end
        // loss of one peak
        P_D1M: begin
          p     <= 64'(m_d1);
          state <= P_CHK;
        end
        P_CHK: begin
          if (d1c == '0 || dd <= 32'(d1c)) begin
            state <= S_FIN;
          end else begin
            d1    <= 32'(d1c);
            d2    <= dd - 32'(d1c);
            state <= P_PRM;
          end
        end
        P_PRM: begin
          div_num    <= {m_pr, 8'b0};
          div_den    <= dd;
          req.div_go <= 1'b1;
          state      <= P_TDIV;
        end
        P_TDIV: begin
          if (rsp.div_done) begin
            div_num    <= {quot[DIV_N-17:0], 16'b0};
            div_den    <= DIV_D'(f);
            req.div_go <= 1'b1;
            state      <= P_QDIV;
          end
        end
        P_QDIV: begin
          if (rsp.div_done) begin
            sq_in       <= quot[SQ_W-1:0];
            req.sqrt_go <= 1'b1;
            state       <= P_ROOT;
          end
        end
        P_ROOT: begin
          if (rsp.sqrt_done) begin
            p     <= 64'(root);
            state <= P_F1;
          end
        end
        P_F1: begin
          // p holds the root here, product formed through m_k
          p     <= 64'(m_k);
          state <= P_H;
        end
        P_H: begin
          f1    <= (f1c == '0) ? 32'd1 : f1c;
          ps    <= H_W'(m_z);
          state <= P_TERM;
        end
        P_TERM: begin
          h     <= szx + ps - phx;
          state <= P_TW;
        end
        P_TW: begin
          div_num    <= DIV_N'({habs20, 16'b0});
          div_den    <= f1;
          req.div_go <= 1'b1;
          state      <= P_ACC;
        end
        P_ACC: begin
          if (rsp.div_done) begin
            state <= S_FIN;
            // peak counts when its loss is at least 6 dB
            if (!hpos || quot <= DIV_N'(TERM_MAX)) begin
              loss <= (total > (DIV_N+1)'(SAT32)) ? SAT32 : total[31:0];
              if (peaks != SAT13) peaks <= peaks + 13'd1;
            end
          end
        end
        S_FIN: begin
          if (ent.last) begin
            out_valid <= 1'b1;
            out_short <= ent.short_p;
            out_loss  <= ent.short_p ? 16'd0 :
                         ((loss > 32'h0000FFFF) ? 16'hFFFF : loss[15:0]);
            out_peaks <= ent.short_p ? 13'd0 : peaks;
            loss      <= '0;
            peaks     <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/terrain_knife_edge_loss.sv
// top level of the knife-edge diffraction loss block
//
// channel  dir  tdata                                       tuser          tlast
// s_*      in   [23:0] pos_x [47:24] pos_y [71:48] height   [1:0] kind     path_last
//               [85:72] freq_mhz [87:86] zero
// m_*      out  [15:0] loss_db [28:16] peak_count           short_profile  none
//               [31:29] zero
//
// samples that are neither peaks nor path ends stay in the front; a start point is taken in the back's idle state
// end points and peaks are both paced by the shared
// one-bit-per-cycle divider (72 steps) and square root (27 steps)
// a four-entry job queue lets the front keep taking beats while the back works
// the back does not start a new job while a result beat waits on m_tready
// rst is synchronous and clears the path, the queue and the running sum
`default_nettype none
module terrain_knife_edge_loss
  import tkel_pkg::*;
#(
  parameter int MAX_SAMPLES   = 8192,
  parameter int POS_FRAC_BITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [87:0] s_tdata,   // pos_x, pos_y, height, freq_mhz, zero pad
  input  wire logic [1:0]  s_tuser,   // kind
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // loss_db, peak_count, zero pad
  output logic             m_tuser    // short_profile
);

  tkel_ent_t        push_ent;
  tkel_ent_t        head;
  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  tkel_req_t        req;
  tkel_rsp_t        rsp;
  logic [DIV_N-1:0] div_num;
  logic [DIV_D-1:0] div_den;
  logic [SQ_W-1:0]  sq_in;
  logic [DIV_N-1:0] quot;
  logic [RT_W-1:0]  root;
  logic [15:0]      loss_db;
  logic [12:0]      peak_count;

  // intake and peak detection
  tkel_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk, .rst,
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .kind        (s_tuser),
    .pos_x       (s_tdata[23:0]),
    .pos_y       (s_tdata[47:24]),
    .height      (s_tdata[71:48]),
    .freq_mhz    (s_tdata[85:72]),
    .path_last   (s_tlast),
    .push, .push_ent, .full
  );

  // job queue
  tkel_fifo u_fifo (
    .clk, .rst, .push, .push_ent, .full, .pop, .empty, .head
  );

  // shared divide and square root
  tkel_arith u_arith (
    .clk, .rst, .req, .div_num, .div_den, .sq_in, .rsp, .quot, .root
  );

  // geometry, loss and result
  tkel_back #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_back (
    .clk, .rst, .empty, .head, .pop, .req, .div_num, .div_den, .sq_in,
    .rsp, .quot, .root,
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_loss  (loss_db),
    .out_peaks (peak_count),
    .out_short (m_tuser)
  );

  assign m_tdata = {3'b000, peak_count, loss_db};

  // checks
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("queue written while full");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!m_tvalid && !empty)) else $error("job taken while result pending");
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 32'd0)) else $error("short profile with loss");
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(req.div_go && req.sqrt_go)) else $error("both units started together");

endmodule
`default_nettype wire

>>> bench/tkel_checker.sv
// checker for the knife-edge loss block: watches both channels, predicts and compares
`default_nettype none
module tkel_checker
  import tkel_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [87:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [31:0] m_tdata,
  input  wire logic        m_tuser,
  output int               errors,
  output int               pending
);

  localparam int          PROFILE_MAX = 8192;
  localparam longint      SIX_DB      = 393216;
  localparam longint      Z_SCALE     = 4096;

  typedef struct {
    logic [15:0] loss;
    logic [12:0] peaks;
    logic        short_p;
  } path_loss_t;

  path_loss_t loss_q[$];

  // path state
  longint          end_a[3];
  longint          ray_step[3];
  longint unsigned flat_len;
  longint unsigned carrier;
  longint          h_prev2;
  longint          h_prev1;
  int unsigned     n_taken;
  longint unsigned loss_acc;
  int unsigned     edge_cnt;

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned absval(input longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint sx24(input logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  task automatic restart_profile();
    n_taken  = 0;
    loss_acc = 0;
    edge_cnt = 0;
    h_prev2  = 0;
    h_prev1  = 0;
  endtask

  // ray step scaled to 7.5 m and horizontal length
  task automatic set_far_end(input longint ex, input longint ey, input longint ez,
                             input longint unsigned f);
    longint          dl[3];
    longint unsigned sq;
    longint unsigned hl;
    longint unsigned len3;
    longint unsigned m;
    dl[0] = ex - end_a[0];
    dl[1] = ey - end_a[1];
    dl[2] = ez - end_a[2];
    sq = absval(dl[0]) * absval(dl[0]) + absval(dl[1]) * absval(dl[1]);
    hl = floor_root(sq);
    flat_len = hl > 64'hFFFFFF ? 64'hFFFFFF : hl;
    sq += absval(dl[2]) * absval(dl[2]);
    len3 = floor_root(sq);
    for (int i = 0; i < 3; i++) begin
      if (len3 == 0) begin
        ray_step[i] = 0;
      end else begin
        m = (absval(dl[i]) * STEP_Q16 + len3 / 2) / len3;
        ray_step[i] = dl[i] < 0 ? -longint'(m) : longint'(m);
      end
    end
    carrier = f;
    restart_profile();
  endtask

  // loss of one knife edge at step c
  task automatic add_edge(input longint unsigned c, input longint peak_h);
    longint unsigned hstep, d1, d, d2, prod, t, q, f, f1, term;
    longint          ray_z, h, a;
    hstep = floor_root(absval(ray_step[0]) * absval(ray_step[0]) +
                       absval(ray_step[1]) * absval(ray_step[1]));
    d1 = (c * hstep) >> 8;
    d  = flat_len << 4;
    if (d1 == 0 || d <= d1) return;
    d2   = d - d1;
    prod = d1 * d2;
    t    = ((prod / d) << 8) + (((prod % d) << 8) / d);
    f    = carrier != 0 ? carrier : 1;
    q    = (t << 16) / f;
    f1   = (floor_root(q) * K173_Q16 + 32768) >> 16;
    if (f1 == 0) f1 = 1;
    ray_z = end_a[2] * Z_SCALE + ray_step[2] * longint'(c);
    h     = ray_z - peak_h * Z_SCALE;
    term  = (absval(h) * 20 * 65536) / f1;
    a = h > 0 ? longint'(TEN_DB_Q16) - longint'(term) : longint'(TEN_DB_Q16) + longint'(term);
    if (a < SIX_DB) return;
    loss_acc += longint'(a) >>> 8;
    if (loss_acc > 64'hFFFFFFFF) loss_acc = 64'hFFFFFFFF;
    if (edge_cnt < 8191) edge_cnt++;
  endtask

  task automatic take_beat(input logic [1:0] kind, input logic [87:0] d, input logic last);
    longint     x, y, z;
    path_loss_t r;
    x = sx24(d[23:0]);
    y = sx24(d[47:24]);
    z = sx24(d[71:48]);
    case (kind)
      KIND_START: begin
        end_a[0] = x;
        end_a[1] = y;
        end_a[2] = z;
        restart_profile();
      end
      KIND_END: begin
        set_far_end(x, y, z, longint'(d[85:72]));
      end
      KIND_SAMPLE: begin
        if (n_taken < PROFILE_MAX) begin
          if (n_taken >= 2 && h_prev1 > h_prev2 && h_prev1 > z)
            add_edge(n_taken - 1, h_prev1);
          h_prev2 = h_prev1;
          h_prev1 = z;
          n_taken++;
        end
        if (last) begin
          if (n_taken < 4) begin
            r.loss = 0;
            r.peaks = 0;
            r.short_p = 1'b1;
          end else begin
            r.loss = loss_acc > 64'hFFFF ? 16'hFFFF : loss_acc[15:0];
            r.peaks = edge_cnt[12:0];
            r.short_p = 1'b0;
          end
          loss_q.insert(loss_q.size(), r);
          restart_profile();
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      end_a[i] = 0;
      ray_step[i] = 0;
    end
    flat_len = 0;
    carrier = 0;
    restart_profile();
  end

  assign pending = loss_q.size();

  // input and result beats
  always @(posedge clk) begin
    path_loss_t e;
    if (!rst) begin
      if (s_tvalid && s_tready) take_beat(s_tuser, s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (loss_q.size() == 0) begin
          $error("result beat with no result expected: %h", m_tdata);
          errors++;
        end else begin
          e = loss_q.pop_front();
          if (m_tdata[15:0] !== e.loss) begin
            $error("loss_db expected %0d actual %0d", e.loss, m_tdata[15:0]);
            errors++;
          end
          if (m_tdata[28:16] !== e.peaks) begin
            $error("peak_count expected %0d actual %0d", e.peaks, m_tdata[28:16]);
            errors++;
          end
          if (m_tuser !== e.short_p) begin
            $error("short_profile expected %0d actual %0d", e.short_p, m_tuser);
            errors++;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> bench/testbench.sv
// testbench top: stimulus, flow control and verdict for the knife-edge loss block
`default_nettype none
module testbench;
  import tkel_pkg::*;

  localparam int     RANDOM_BEATS = 1700;
  localparam int     FLAT_BEATS   = 300;
  localparam longint CYCLE_LIMIT  = 3000000;
  localparam int     HOLD_CYCLES  = 6000;
  localparam logic [1:0] KIND_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  int          errors;
  int          pending;
  bit          send_gaps = 1'b1;
  bit          hold_go = 1'b0;
  longint      cycles = 0;

  always #6 clk = ~clk;

  terrain_knife_edge_loss u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  tkel_checker u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stalls, a quiet stretch and one long hold-off
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (cycles % 40000 < 8000) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 7);
    end
  end

  // offer one beat and wait for it to be taken
  task automatic put_beat(input logic [1:0] kind, input logic [23:0] x, input logic [23:0] y,
                          input logic [23:0] z, input logic [13:0] f, input logic last);
    bit taken;
    if (send_gaps && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, f, z, y, x};
    s_tlast  <= last;
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // one profile of n samples around height base with occasional bumps
  task automatic run_profile(input int n, input int base, input int bump);
    logic [23:0] h;
    for (int i = 0; i < n; i++) begin
      h = 24'(base + int'($urandom_range(0, 64)) - 32);
      if ($urandom_range(3) == 0) h = 24'(base + int'($urandom_range(0, bump)));
      put_beat(KIND_SAMPLE, 24'($urandom), 24'($urandom), h, 14'($urandom), i == n - 1);
    end
  endtask

  initial begin
    int n;
    int base;
    int sent;
    logic [23:0] ax, ay;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, short profiles, coincident points, odd frequencies
    put_beat(KIND_START, 24'h800000, 24'h7FFFFF, 24'h000000, 14'd0, 1'b0);
    put_beat(KIND_END, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 14'd16383, 1'b0);
    put_beat(KIND_SAMPLE, 24'd0, 24'd0, 24'h7FFFFF, 14'd0, 1'b1);
    put_beat(KIND_SAMPLE, 24'd0, 24'd0, 24'h800000, 14'd0, 1'b0);
    put_beat(KIND_SAMPLE, 24'd0, 24'd0, 24'h7FFFFF, 14'd0, 1'b1);
    put_beat(KIND_START, 24'd0, 24'd0, 24'd1600, 14'd1, 1'b0);
    put_beat(KIND_END, 24'd160000, 24'd0, 24'd1600, 14'd0, 1'b0);
    put_beat(KIND_SAMPLE, 24'd0, 24'd0, 24'd1500, 14'd0, 1'b0);
    put_beat(KIND_SAMPLE, 24'd0, 24'd0, 24'd1700, 14'd0, 1'b0);
    put_beat(KIND_SAMPLE, 24'd0, 24'd0, 24'd1500, 14'd0, 1'b0);
    put_beat(KIND_SAMPLE, 24'd0, 24'd0, 24'd2600, 14'd0, 1'b0);
    put_beat(KIND_NONE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 14'h3FFF, 1'b1);
    put_beat(KIND_SAMPLE, 24'd0, 24'd0, 24'd1500, 14'd0, 1'b1);
    put_beat(KIND_END, 24'd0, 24'd0, 24'd1600, 14'd10000, 1'b0);
    run_profile(6, 1600, 400);
    put_beat(KIND_START, 24'd0, 24'd0, 24'd0, 14'd0, 1'b0);
    put_beat(KIND_END, 24'd16, 24'd0, 24'd0, 14'd1, 1'b0);
    run_profile(5, 0, 200);
    drain();

    // long mostly flat profile, sent with no gaps
    put_beat(KIND_START, 24'd0, 24'd0, 24'd800, 14'd0, 1'b0);
    put_beat(KIND_END, 24'd400000, 24'd300000, 24'd800, 14'd900, 1'b0);
    send_gaps = 1'b0;
    for (int i = 0; i < FLAT_BEATS; i++)
      put_beat(KIND_SAMPLE, 24'd0, 24'd0, (i % 100 == 50) ? 24'd1200 : 24'd790, 14'd0,
               i == FLAT_BEATS - 1);
    send_gaps = 1'b1;
    drain();

    // random paths
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      if (sent > 300 && !hold_go) hold_go <= 1'b1;
      send_gaps = !(sent > 1000 && sent < 1300);
      if ($urandom_range(19) == 0) begin
        put_beat(2'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 14'($urandom),
                 1'($urandom));
        sent++;
      end else begin
        base = int'($urandom_range(0, 32000)) - 4000;
        ax = 24'($urandom_range(0, 200000) - 100000);
        ay = 24'($urandom_range(0, 200000) - 100000);
        put_beat(KIND_START, ax, ay, 24'(base), 14'($urandom), 1'($urandom));
        put_beat(KIND_END, 24'(ax + $urandom_range(0, 400000) - 200000),
                 24'(ay + $urandom_range(0, 400000) - 200000),
                 24'(base + int'($urandom_range(0, 2000)) - 1000),
                 14'($urandom_range(1, 10000)), 1'($urandom));
        n = ($urandom_range(9) == 0) ? int'($urandom_range(1, 3)) : int'($urandom_range(4, 30));
        run_profile(n, base, 800);
        sent += n + 2;
      end
      if (sent > 1500 && sent < 1540) drain();
    end
    drain();
    repeat (600) @(posedge clk);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
